// File: hw/rtl/gipe_pkg.sv
`timescale 1ns / 1ps

package gipe_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 256;
    localparam int MAX_ROWS_DEFAULT    = 256;

    localparam int PIXEL_W     = 8;
    localparam int SIZE_W      = 9;
    localparam int CENTER_W    = 8;
    localparam int DIST_W      = 8;
    localparam int INDEX_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int OUT_DATA_W  = INDEX_W + 4 * DIST_W;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_ROW    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COLUMN = 2'd3;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    localparam int RESULT_DEPTH = 4;

    typedef struct packed {
        logic [DIST_W-1:0] a_inner;
        logic [DIST_W-1:0] a_outer;
        logic [DIST_W-1:0] b_inner;
        logic [DIST_W-1:0] b_outer;
    } tracker_t;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] index;
        tracker_t           trk;
        logic               last;
    } result_t;

    function automatic tracker_t track_ink(
        input tracker_t          t,
        input logic              ink,
        input logic              is_before,
        input logic              is_after,
        input logic [DIST_W-1:0] d
    );
        tracker_t r;
        r = t;
        if (ink && is_before) begin
            if (t.b_outer == '0) begin
                r.b_outer = d;
            end
            r.b_inner = d;
        end else if (ink && is_after) begin
            r.a_outer = d;
            if (t.a_inner == '0) begin
                r.a_inner = d;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/glyph_ink_profile_extractor_core.sv
`timescale 1ns / 1ps

// Glyph ink profile extractor.
// s_ channel: one raster pixel per beat (s_tdata = pixel_value), row by row.
// m_ channel: profile beats. m_tuser = profile_kind (0 row, 1 column),
// m_tdata = line_index, before_outer, before_inner, after_outer, after_inner
// from the lowest byte up, m_tlast = last profile caused by that pixel.
// Each pixel of the last row gives a column profile; the last pixel of every
// row gives a row profile; at the final pixel the column profile goes first.
// Throughput: one pixel per cycle while s_tready is high. Column trackers live
// in a one-port-read, one-port-write memory; a pixel reads its column when
// accepted and writes it back the next cycle, with a bypass when the same
// column follows at once. Profiles pass the read-modify-write stage and then
// queue in a four-beat result buffer, from which they are offered; s_tready
// drops when the buffer cannot take what is in flight, so a stalled receiver
// backs up to the pixel side. The last pixel of an image carries two profiles
// and can hold off the next pixel; with height 1 that holds at every row end.
// Reset (aresetn low, synchronous): registers return to 256 x 256 with the
// center at 0,0, positions go to the first pixel and the buffer empties.
// Configuration writes only between images.

module glyph_ink_profile_extractor_core
    import gipe_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS    = MAX_ROWS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,    // [7:0] pixel_value

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // line_index, before_outer, before_inner,
                                               // after_outer, after_inner
    output logic                   m_tuser,    // profile_kind
    output logic                   m_tlast,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int PW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CXW = ($clog2(MAX_COLUMNS + 1) > SIZE_W) ? $clog2(MAX_COLUMNS + 1) : SIZE_W;
    localparam int RXW = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
    localparam int CDW = (PW > CENTER_W) ? PW : CENTER_W;
    localparam int RDW = (RW > CENTER_W) ? RW : CENTER_W;
    localparam int FAW = $clog2(RESULT_DEPTH);
    localparam int FCW = $clog2(RESULT_DEPTH + 1);

    // configuration
    logic [SIZE_W-1:0]   image_width_reg;
    logic [SIZE_W-1:0]   image_height_reg;
    logic [CENTER_W-1:0] center_row_reg;
    logic [CENTER_W-1:0] center_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= SIZE_W'(256);
            image_height_reg <= SIZE_W'(256);
            center_row_reg   <= '0;
            center_col_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT:  image_height_reg <= cfg_wdata;
                REG_CENTER_ROW:    center_row_reg   <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_COLUMN: center_col_reg   <= cfg_wdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // position and row tracking
    logic [PW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    tracker_t      row_trk_reg, row_trk_next;

    logic [CXW-1:0] w_ext, w_eff;
    logic [RXW-1:0] h_ext, h_eff;
    logic           row_end, last_row, accept, ink;

    logic [CDW-1:0]    col_x, cc_x, col_diff;
    logic [RDW-1:0]    row_x, cr_x, row_diff;
    logic              col_before, col_after, row_before, row_after;
    logic [DIST_W-1:0] col_dist, row_dist;

    assign accept = s_tvalid && s_tready;
    assign ink    = (s_tdata != '0);

    always_comb begin
        w_ext = CXW'(image_width_reg);
        if (w_ext == '0) begin
            w_eff = CXW'(1);
        end else if (w_ext > CXW'(MAX_COLUMNS)) begin
            w_eff = CXW'(MAX_COLUMNS);
        end else begin
            w_eff = w_ext;
        end
        h_ext = RXW'(image_height_reg);
        if (h_ext == '0) begin
            h_eff = RXW'(1);
        end else if (h_ext > RXW'(MAX_ROWS)) begin
            h_eff = RXW'(MAX_ROWS);
        end else begin
            h_eff = h_ext;
        end
        row_end  = (CXW'(col_pos_reg) + CXW'(1)) >= w_eff;
        last_row = (RXW'(row_pos_reg) + RXW'(1)) >= h_eff;

        col_x      = CDW'(col_pos_reg);
        cc_x       = CDW'(center_col_reg);
        col_before = col_x < cc_x;
        col_after  = col_x > cc_x;
        col_diff   = col_before ? (cc_x - col_x) : (col_x - cc_x);
        col_dist   = (col_diff > CDW'(255)) ? DIST_W'(255) : DIST_W'(col_diff);

        row_x      = RDW'(row_pos_reg);
        cr_x       = RDW'(center_row_reg);
        row_before = row_x < cr_x;
        row_after  = row_x > cr_x;
        row_diff   = row_before ? (cr_x - row_x) : (row_x - cr_x);
        row_dist   = (row_diff > RDW'(255)) ? DIST_W'(255) : DIST_W'(row_diff);

        row_trk_next = track_ink((col_pos_reg == '0) ? tracker_t'('0) : row_trk_reg,
                                 ink, col_before, col_after, col_dist);

        if (row_end) begin
            col_pos_next = '0;
            row_pos_next = last_row ? '0 : row_pos_reg + RW'(1);
        end else begin
            col_pos_next = col_pos_reg + PW'(1);
            row_pos_next = row_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            row_trk_reg <= '0;
        end else if (accept) begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            row_trk_reg <= row_trk_next;
        end
    end

    // read-modify-write stage on the column store
    logic              s1_valid_reg;
    logic              s1_fwd_reg;
    tracker_t          s1_fwd_data_reg;
    logic [PW-1:0]     s1_addr_reg;
    logic [RW-1:0]     s1_row_reg;
    logic              s1_clear_reg, s1_ink_reg, s1_before_reg, s1_after_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    logic              s1_last_row_reg, s1_row_end_reg;
    tracker_t          s1_row_trk_reg;

    tracker_t mem_rd_data, col_base, col_upd;

    gipe_col_mem #(
        .DEPTH (MAX_COLUMNS)
    ) u_col_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (mem_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (col_upd)
    );

    always_comb begin
        if (s1_clear_reg) begin
            col_base = '0;
        end else if (s1_fwd_reg) begin
            col_base = s1_fwd_data_reg;
        end else begin
            col_base = mem_rd_data;
        end
        col_upd = track_ink(col_base, s1_ink_reg, s1_before_reg, s1_after_reg, s1_dist_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                s1_fwd_reg <= s1_valid_reg && (s1_addr_reg == col_pos_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_fwd_data_reg <= col_upd;
        if (accept) begin
            s1_addr_reg     <= col_pos_reg;
            s1_row_reg      <= row_pos_reg;
            s1_clear_reg    <= (row_pos_reg == '0);
            s1_ink_reg      <= ink;
            s1_before_reg   <= row_before;
            s1_after_reg    <= row_after;
            s1_dist_reg     <= row_dist;
            s1_last_row_reg <= last_row;
            s1_row_end_reg  <= row_end;
            s1_row_trk_reg  <= row_trk_next;
        end
    end

    // result buffer
    result_t        fifo_mem [RESULT_DEPTH];
    logic [FAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FCW-1:0] count_reg;
    logic           push_col, push_row, pop;
    logic [1:0]     push_n;
    result_t        col_result, row_result, head;

    assign push_col = s1_valid_reg && s1_last_row_reg;
    assign push_row = s1_valid_reg && s1_row_end_reg;
    assign push_n   = 2'(push_col) + 2'(push_row);
    assign pop      = m_tvalid && m_tready;

    assign col_result = '{kind: KIND_COLUMN, index: INDEX_W'(s1_addr_reg), trk: col_upd,
                          last: !s1_row_end_reg};
    assign row_result = '{kind: KIND_ROW, index: INDEX_W'(s1_row_reg), trk: s1_row_trk_reg,
                          last: 1'b1};

    assign s_tready = aresetn &&
        ((FCW+1)'(count_reg) + (FCW+1)'(push_n) + (FCW+1)'(2) <= (FCW+1)'(RESULT_DEPTH));

    always_ff @(posedge aclk) begin
        if (push_col) begin
            fifo_mem[wr_ptr_reg] <= col_result;
        end
        if (push_row) begin
            fifo_mem[push_col ? wr_ptr_reg + FAW'(1) : wr_ptr_reg] <= row_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FAW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FAW'(pop);
            count_reg  <= count_reg + FCW'(push_n) - FCW'(pop);
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head.trk.a_inner, head.trk.a_outer, head.trk.b_inner,
                       head.trk.b_outer, head.index};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // checks
    a_buffer_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FCW'(RESULT_DEPTH))
        else $error("result buffer overflow");

    a_bypass_source : assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_fwd_reg) |-> ($past(s1_valid_reg) &&
                                          s1_addr_reg == $past(s1_addr_reg)))
        else $error("column bypass without matching write");

    a_row_ends_run : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ROW) |-> m_tlast)
        else $error("row profile not marked last");

    a_pair_order : assert property (@(posedge aclk) disable iff (!aresetn)
        (push_col && push_row) |-> (count_reg + FCW'(2) <= FCW'(RESULT_DEPTH)))
        else $error("no room for profile pair");

endmodule

// File: hw/rtl/gipe_col_mem.sv
`timescale 1ns / 1ps

module gipe_col_mem
    import gipe_pkg::*;
#(
    parameter int DEPTH = MAX_COLUMNS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output tracker_t                 rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  tracker_t                 wr_data
);

    tracker_t mem [DEPTH];
    tracker_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import gipe_pkg::*;

    localparam int PIXEL_TARGET = 1450;
    localparam int LONG_HOLD    = 300;
    localparam int STUCK_LIMIT  = 2000;
    localparam int SETTLE       = 8;

    // ink on both sides of centre row 1 and centre column 2, and on the centre lines
    localparam logic [PIXEL_W-1:0] FIRST_GLYPH [12] = '{
        8'h00, 8'hFF, 8'h01, 8'h80,
        8'h10, 8'h00, 8'h20, 8'h00,
        8'h7F, 8'hFE, 8'h00, 8'h40
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor state
    logic [SIZE_W-1:0]   width_reg  = 9'd256;
    logic [SIZE_W-1:0]   height_reg = 9'd256;
    logic [CENTER_W-1:0] ctr_row    = '0;
    logic [CENTER_W-1:0] ctr_col    = '0;
    tracker_t            col_ink [MAX_COLUMNS_DEFAULT];
    tracker_t            row_ink    = '0;
    int                  at_row     = 0;
    int                  at_col     = 0;

    result_t            profile_q [$];
    logic [PIXEL_W-1:0] pixel_q [$];

    int pixels_pushed = 0;
    int pixels_taken  = 0;
    int beats_seen    = 0;
    int error_count   = 0;
    int stuck_cycles  = 0;
    int settings_used = 0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int hold_left     = 0;
    bit quiet_phase     = 1'b0;
    bit start_long_hold = 1'b0;
    bit hold_done       = 1'b0;

    glyph_ink_profile_extractor_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic int eff_size(input int v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic int draw_gap();
        int roll;
        if (quiet_phase) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic tracker_t note_ink(input tracker_t t, input int pos, input int ctr,
                                          input bit ink);
        tracker_t r;
        r = t;
        if (ink && pos < ctr) begin
            if (r.b_outer == '0) begin
                r.b_outer = DIST_W'(ctr - pos);
            end
            r.b_inner = DIST_W'(ctr - pos);
        end else if (ink && pos > ctr) begin
            r.a_outer = DIST_W'(pos - ctr);
            if (r.a_inner == '0) begin
                r.a_inner = DIST_W'(pos - ctr);
            end
        end
        return r;
    endfunction

    function automatic void predict_pixel(input logic [PIXEL_W-1:0] px);
        int      w, h, c, r;
        bit      ink, row_end, last_row;
        result_t res;
        w        = eff_size(int'(width_reg));
        h        = eff_size(int'(height_reg));
        c        = at_col;
        r        = at_row;
        ink      = (px != '0);
        row_end  = (c + 1 >= w);
        last_row = (r + 1 >= h);
        if (r == 0) begin
            col_ink[c] = '0;
        end
        col_ink[c] = note_ink(col_ink[c], r, int'(ctr_row), ink);
        if (c == 0) begin
            row_ink = '0;
        end
        row_ink = note_ink(row_ink, c, int'(ctr_col), ink);
        if (last_row) begin
            res.kind  = KIND_COLUMN;
            res.index = INDEX_W'(c);
            res.trk   = col_ink[c];
            res.last  = !row_end;
            profile_q.push_back(res);
        end
        if (row_end) begin
            res.kind  = KIND_ROW;
            res.index = INDEX_W'(r);
            res.trk   = row_ink;
            res.last  = 1'b1;
            profile_q.push_back(res);
            at_col = 0;
            at_row = last_row ? 0 : r + 1;
        end else begin
            at_col = c + 1;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            note_mismatch($sformatf("beat %0d %s: expected %h, got %h",
                                    beats_seen, name, want, got));
        end
    endfunction

    // pixel side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata);
                pixels_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                    tx_gap = draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // profile side
    always @(posedge aclk) begin : profile_side
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (profile_q.size() == 0) begin
                    note_mismatch($sformatf("beat %0d unexpected: tuser %b tdata %h tlast %b",
                                            beats_seen, m_tuser, m_tdata, m_tlast));
                end else begin
                    want = profile_q.pop_front();
                    check_field("profile_kind", 8'(want.kind), 8'(m_tuser));
                    check_field("line_index", want.index, m_tdata[7:0]);
                    check_field("before_outer", want.trk.b_outer, m_tdata[15:8]);
                    check_field("before_inner", want.trk.b_inner, m_tdata[23:16]);
                    check_field("after_outer", want.trk.a_outer, m_tdata[31:24]);
                    check_field("after_inner", want.trk.a_inner, m_tdata[39:32]);
                    check_field("last_of_run", 8'(want.last), 8'(m_tlast));
                end
                rx_gap = draw_gap();
            end
            if (start_long_hold && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no beat for %0d cycles", stuck_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_IMAGE_WIDTH:   width_reg  = value[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  height_reg = value[SIZE_W-1:0];
            REG_CENTER_ROW:    ctr_row    = value[CENTER_W-1:0];
            REG_CENTER_COLUMN: ctr_col    = value[CENTER_W-1:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int cr, input int cc);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CENTER_ROW, cr);
        write_reg(REG_CENTER_COLUMN, cc);
        settings_used++;
    endtask

    task automatic push_pixels(input int count, input int density);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < density) begin
                pixel_q.push_back(PIXEL_W'($urandom_range(1, 255)));
            end else begin
                pixel_q.push_back('0);
            end
            pixels_pushed++;
        end
    endtask

    // wait out every expected beat, then the pipeline
    task automatic drain();
        while (pixels_taken != pixels_pushed || profile_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int pick_center(input int n);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(0, 255);
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    initial begin : stimulus
        int wv, hv, w_eff, h_eff, images, density;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_geometry(4, 3, 1, 2);
        foreach (FIRST_GLYPH[i]) begin
            pixel_q.push_back(FIRST_GLYPH[i]);
            pixels_pushed++;
        end
        drain();

        // shrink width and height part way through an image
        set_geometry(4, 4, 1, 2);
        push_pixels(6, 60);
        drain();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        push_pixels(1, 100);
        drain();

        // sink stalls for a long stretch while pixels keep coming
        set_geometry(8, 2, 0, 7);
        quiet_phase     = 1'b1;
        start_long_hold = 1'b1;
        push_pixels(64, 50);
        drain();
        quiet_phase = 1'b0;

        while (pixels_pushed < PIXEL_TARGET) begin
            case ($urandom_range(0, 11))
                0:       wv = 0;
                1:       wv = 1;
                2:       wv = 256;
                3:       wv = 511;
                default: wv = $urandom_range(2, 16);
            endcase
            w_eff = eff_size(wv);
            if (w_eff > 16) begin
                hv = $urandom_range(0, 2);
            end else begin
                case ($urandom_range(0, 9))
                    0:       hv = 0;
                    1:       hv = 1;
                    2:       hv = (w_eff <= 2) ? ($urandom_range(0, 1) ? 256 : 511) : 24;
                    default: hv = $urandom_range(2, 12);
                endcase
            end
            h_eff = eff_size(hv);
            case ($urandom_range(0, 7))
                0:       density = 0;
                1:       density = 100;
                default: density = $urandom_range(5, 95);
            endcase
            images      = (w_eff * h_eff > 64) ? 1 : $urandom_range(1, 3);
            quiet_phase = ($urandom_range(0, 4) == 0);
            set_geometry(wv, hv, pick_center(h_eff), pick_center(w_eff));
            push_pixels(images * w_eff * h_eff, density);
            drain();
        end

        if (profile_q.size() != 0) begin
            note_mismatch($sformatf("%0d profiles never arrived", profile_q.size()));
        end
        $display("%0d pixels in %0d register settings, %0d profile beats checked;",
                 pixels_taken, settings_used, beats_seen);
        $display("sizes 0 to 511 written, centres inside and outside, one %0d-cycle sink stall.",
                 LONG_HOLD);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: glyph_ink_profile_extractor_core.f
hw/rtl/gipe_pkg.sv
hw/rtl/gipe_col_mem.sv
hw/rtl/glyph_ink_profile_extractor_core.sv
sim/tb.sv
